// File: hw/rtl/ddma_pkg.sv
// ----------------------------------------------------------------------------
// ddma_pkg
// Shared widths, port codes and types for the port-driven disk DMA controller.
// ----------------------------------------------------------------------------
package ddma_pkg;

    localparam int BYTE_W  = 8;
    localparam int VAL_W   = 32;
    localparam int LOC_W   = 12;
    localparam int OP_W    = 2;
    localparam int PHASE_W = 2;

    // Special values seen on the port.
    localparam logic [VAL_W-1:0] CODE_ERROR    = 32'hFFFF_FFFE;
    localparam logic [VAL_W-1:0] CODE_NEXT     = 32'hFFFF_FFFC;
    localparam logic [VAL_W-1:0] CODE_NOOP     = 32'hFFFF_FFFD;
    localparam logic [VAL_W-1:0] CODE_WRITE    = 32'hFFFF_FFFF;
    localparam logic [VAL_W-1:0] CODE_LITERAL3 = 32'd3;

    typedef enum logic [OP_W-1:0] {
        OP_PORT    = 2'd0,
        OP_MEM_WR  = 2'd1,
        OP_MEM_RD  = 2'd2,
        OP_DISK_WR = 2'd3
    } t_op;

    // Copy request handed from the port decoder to the copy sequencer.
    typedef struct packed {
        logic go;
        logic to_disk;
    } t_copy_cmd;

endpackage

// File: hw/rtl/port_driven_disk_dma_controller.sv
// ----------------------------------------------------------------------------
// port_driven_disk_dma_controller
// Port-driven DMA between a byte-wide disk store and a main-memory store,
// with direct byte reads and writes of main memory and byte preloads of the disk store.
// ----------------------------------------------------------------------------
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+-------------------------------
//   input   | in        | i_valid / o_stall   | i_operation, i_value, i_location
//   output  | out       | o_valid / i_stall   | o_reply, o_phase
//
// A port item without a copy, a memory write or a disk preload loads the
// result register directly; a memory read passes through the read step.
// A seek or write request moves one byte per cycle through the shared copy
// pointers, then a drain step; the source store's read is registered, so
// each byte is written in the cycle after it is read. After reset both
// stores are cleared, one address per cycle, while o_stall stays high.
// A new item is taken only while the result register is free or being taken.
// ----------------------------------------------------------------------------
module port_driven_disk_dma_controller import ddma_pkg::*; #(
    parameter int MEM_WORDS  = 4096,
    parameter int DISK_WORDS = 4096
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [OP_W-1:0]    i_operation,
    input  logic [VAL_W-1:0]   i_value,
    input  logic [LOC_W-1:0]   i_location,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [VAL_W-1:0]   o_reply,
    output logic [PHASE_W-1:0] o_phase
);

    localparam int MAW       = $clog2(MEM_WORDS);
    localparam int DAW       = $clog2(DISK_WORDS);
    localparam int PW        = ((MAW > DAW) ? MAW : DAW) + 1;
    localparam int CLR_WORDS = (MEM_WORDS > DISK_WORDS) ? MEM_WORDS : DISK_WORDS;
    localparam logic [PW-1:0] MemEnd  = PW'(MEM_WORDS);
    localparam logic [PW-1:0] DiskEnd = PW'(DISK_WORDS);
    localparam logic [PW-1:0] ClrLast = PW'(CLR_WORDS - 1);

    typedef enum logic [2:0] {
        S_CLEAR = 3'd0,
        S_IDLE  = 3'd1,
        S_READ  = 3'd2,
        S_COPY  = 3'd3,
        S_DRAIN = 3'd4
    } t_state;

    t_state             r_state;
    logic               r_valid;
    logic [VAL_W-1:0]   r_reply;
    logic [PHASE_W-1:0] r_phase;
    logic [PW-1:0]      r_clr;
    logic [PW-1:0]      r_mptr;
    logic [PW-1:0]      r_dptr;
    logic [MAW-1:0]     r_left;
    logic               r_to_disk;
    logic               r_wpend;
    logic [MAW-1:0]     r_wmaddr;
    logic [DAW-1:0]     r_wdaddr;
    logic               r_rd_ok;

    logic               accept;
    logic               set_valid;
    t_op                op;
    logic [31:0]        loc32;
    logic               loc_in_mem;
    logic               loc_in_disk;
    logic               copy_ok;

    logic [VAL_W-1:0]   port_reply;
    logic [PHASE_W-1:0] port_phase;
    t_copy_cmd          port_cmd;
    logic [MAW-1:0]     port_start;
    logic [MAW-1:0]     port_size;
    logic [DAW-1:0]     port_seek;

    logic               mem_we;
    logic [MAW-1:0]     mem_waddr;
    logic [BYTE_W-1:0]  mem_wdata;
    logic [MAW-1:0]     mem_raddr;
    logic [BYTE_W-1:0]  mem_rdata;
    logic               disk_we;
    logic [DAW-1:0]     disk_waddr;
    logic [BYTE_W-1:0]  disk_wdata;
    logic [DAW-1:0]     disk_raddr;
    logic [BYTE_W-1:0]  disk_rdata;

    assign o_stall     = (r_state != S_IDLE) || (r_valid && i_stall);
    assign accept      = i_valid && !o_stall;
    assign op          = t_op'(i_operation);
    // The result register is loaded by an accepted item other than a memory read, or by the read step.
    assign set_valid   = (accept && op != OP_MEM_RD) || (r_state == S_READ);
    assign loc32       = 32'(i_location);
    assign loc_in_mem  = loc32 < 32'(MEM_WORDS);
    assign loc_in_disk = loc32 < 32'(DISK_WORDS);
    // A copy step is skipped when either side runs past the end of its store.
    assign copy_ok     = (r_mptr < MemEnd) && (r_dptr < DiskEnd);

    ddma_port #(
        .MEM_WORDS  (MEM_WORDS),
        .DISK_WORDS (DISK_WORDS),
        .MAW        (MAW),
        .DAW        (DAW)
    ) u_port (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (accept && op == OP_PORT),
        .i_value (i_value),
        .o_reply (port_reply),
        .o_phase (port_phase),
        .o_cmd   (port_cmd),
        .o_start (port_start),
        .o_size  (port_size),
        .o_seek  (port_seek)
    );

    always_comb begin
        mem_we     = 1'b0;
        mem_waddr  = loc32[MAW-1:0];
        mem_wdata  = i_value[BYTE_W-1:0];
        mem_raddr  = loc32[MAW-1:0];
        disk_we    = 1'b0;
        disk_waddr = loc32[DAW-1:0];
        disk_wdata = i_value[BYTE_W-1:0];
        disk_raddr = r_dptr[DAW-1:0];
        unique case (r_state)
            S_CLEAR: begin
                mem_we     = r_clr < MemEnd;
                mem_waddr  = r_clr[MAW-1:0];
                mem_wdata  = '0;
                disk_we    = r_clr < DiskEnd;
                disk_waddr = r_clr[DAW-1:0];
                disk_wdata = '0;
            end
            S_IDLE: begin
                mem_we  = accept && op == OP_MEM_WR && loc_in_mem;
                disk_we = accept && op == OP_DISK_WR && loc_in_disk;
            end
            S_COPY, S_DRAIN: begin
                mem_raddr = r_mptr[MAW-1:0];
                if (r_to_disk) begin
                    disk_we    = r_wpend;
                    disk_waddr = r_wdaddr;
                    disk_wdata = mem_rdata;
                end else begin
                    mem_we    = r_wpend;
                    mem_waddr = r_wmaddr;
                    mem_wdata = disk_rdata;
                end
            end
            default: begin
            end
        endcase
    end

    ddma_ram #(
        .WORDS (MEM_WORDS),
        .AW    (MAW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    ddma_ram #(
        .WORDS (DISK_WORDS),
        .AW    (DAW)
    ) u_disk (
        .i_clk   (i_clk),
        .i_we    (disk_we),
        .i_waddr (disk_waddr),
        .i_wdata (disk_wdata),
        .i_raddr (disk_raddr),
        .o_rdata (disk_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_valid <= 1'b0;
            r_clr   <= '0;
            r_wpend <= 1'b0;
        end else begin
            if (set_valid) begin
                r_valid <= 1'b1;
            end else if (r_valid && !i_stall) begin
                r_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + PW'(1);
                    if (r_clr == ClrLast) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_rd_ok <= loc_in_mem;
                        if (op == OP_MEM_RD) begin
                            r_state <= S_READ;
                        end else begin
                            r_reply <= (op == OP_PORT) ? port_reply : '0;
                            r_phase <= port_phase;
                        end
                        if (port_cmd.go && port_size != '0) begin
                            r_state   <= S_COPY;
                            r_to_disk <= port_cmd.to_disk;
                            r_mptr    <= PW'(port_start);
                            r_dptr    <= PW'(port_seek);
                            r_left    <= port_size;
                        end
                    end
                end
                S_READ: begin
                    r_reply <= r_rd_ok ? VAL_W'(mem_rdata) : '0;
                    r_phase <= port_phase;
                    r_state <= S_IDLE;
                end
                S_COPY: begin
                    // The source byte is read now and written in the next cycle.
                    r_wpend  <= copy_ok;
                    r_wmaddr <= r_mptr[MAW-1:0];
                    r_wdaddr <= r_dptr[DAW-1:0];
                    r_mptr   <= r_mptr + PW'(1);
                    r_dptr   <= r_dptr + PW'(1);
                    r_left   <= r_left - MAW'(1);
                    if (r_left == MAW'(1)) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_wpend <= 1'b0;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid = r_valid;
    assign o_reply = r_reply;
    assign o_phase = r_phase;

endmodule

// File: hw/rtl/ddma_ram.sv
// ----------------------------------------------------------------------------
// ddma_ram
// Byte-wide store with one write port and one registered read port.
// ----------------------------------------------------------------------------
module ddma_ram import ddma_pkg::*; #(
    parameter int WORDS = 4096,
    parameter int AW    = 12
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [BYTE_W-1:0] i_wdata,
    input  logic [AW-1:0]     i_raddr,
    output logic [BYTE_W-1:0] o_rdata
);

    logic [BYTE_W-1:0] r_mem [WORDS];
    logic [BYTE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/ddma_port.sv
// ----------------------------------------------------------------------------
// ddma_port
// Four-phase port decoder: buffer start, buffer size, requests and hold.
// Holds the buffer registers and the seek position, checks ranges and issues
// copy requests.
// ----------------------------------------------------------------------------
module ddma_port import ddma_pkg::*; #(
    parameter int MEM_WORDS  = 4096,
    parameter int DISK_WORDS = 4096,
    parameter int MAW        = 12,
    parameter int DAW        = 12
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_go,
    input  logic [VAL_W-1:0]   i_value,
    output logic [VAL_W-1:0]   o_reply,
    output logic [PHASE_W-1:0] o_phase,
    output t_copy_cmd          o_cmd,
    output logic [MAW-1:0]     o_start,
    output logic [MAW-1:0]     o_size,
    output logic [DAW-1:0]     o_seek
);

    typedef enum logic [PHASE_W-1:0] {
        PH_START = 2'd0,
        PH_SIZE  = 2'd1,
        PH_REQ   = 2'd2,
        PH_HOLD  = 2'd3
    } t_phase;

    localparam logic [VAL_W:0] MemLim  = (VAL_W+1)'(MEM_WORDS);
    localparam logic [VAL_W:0] DiskLim = (VAL_W+1)'(DISK_WORDS);

    t_phase          r_phase, n_phase;
    logic [MAW-1:0]  r_start, n_start;
    logic [MAW-1:0]  r_size, n_size;
    logic [DAW-1:0]  r_seek, n_seek;
    logic [VAL_W-1:0] reply;
    t_copy_cmd       cmd;
    logic [VAL_W:0]  v_ext;
    logic [VAL_W:0]  end_sum;

    assign v_ext   = {1'b0, i_value};
    // Exact end of the buffer; the extra bit keeps the sum from wrapping.
    assign end_sum = v_ext + (VAL_W+1)'(r_start);

    always_comb begin
        n_phase = r_phase;
        n_start = r_start;
        n_size  = r_size;
        n_seek  = r_seek;
        reply   = '0;
        cmd     = '0;
        unique case (r_phase)
            PH_START: begin
                if (i_value == CODE_NEXT) begin
                    n_phase = PH_SIZE;
                end else if (i_value != '0 && i_value != CODE_ERROR) begin
                    if (v_ext >= MemLim) begin
                        reply = CODE_ERROR;
                    end else begin
                        n_start = i_value[MAW-1:0];
                    end
                end
            end
            PH_SIZE: begin
                if (i_value == CODE_NEXT) begin
                    n_phase = PH_REQ;
                    reply   = CODE_NOOP;
                end else if (i_value == '0 || i_value == CODE_ERROR) begin
                    reply = i_value;
                end else if (end_sum >= MemLim) begin
                    reply = CODE_ERROR;
                end else begin
                    n_size = i_value[MAW-1:0];
                end
            end
            PH_REQ: begin
                if (i_value == CODE_NEXT) begin
                    n_phase = PH_HOLD;
                    reply   = i_value;
                end else if (i_value == CODE_WRITE) begin
                    cmd.go      = 1'b1;
                    cmd.to_disk = 1'b1;
                    reply       = CODE_NOOP;
                end else if (i_value == CODE_ERROR || i_value == CODE_NOOP ||
                             i_value == CODE_LITERAL3) begin
                    reply = i_value;
                end else if (v_ext >= DiskLim) begin
                    reply = CODE_ERROR;
                end else begin
                    n_seek      = i_value[DAW-1:0];
                    cmd.go      = 1'b1;
                    cmd.to_disk = 1'b0;
                    reply       = CODE_NOOP;
                end
            end
            PH_HOLD: begin
                if (i_value == CODE_NEXT) begin
                    n_phase = PH_START;
                end
            end
            default: begin
                n_phase = PH_START;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_START;
            r_start <= '0;
            r_size  <= '0;
            r_seek  <= '0;
        end else if (i_go) begin
            r_phase <= n_phase;
            r_start <= n_start;
            r_size  <= n_size;
            r_seek  <= n_seek;
        end
    end

    assign o_reply     = reply;
    assign o_phase     = i_go ? n_phase : r_phase;
    assign o_cmd.go      = i_go & cmd.go;
    assign o_cmd.to_disk = cmd.to_disk;
    assign o_start     = r_start;
    assign o_size      = r_size;
    // A seek copies from the new position, a write goes to the last one.
    assign o_seek      = n_seek;

endmodule

// File: hw/rtl/ddma_checker.sv
// ----------------------------------------------------------------------------
// ddma_checker
// Port-level checks for the port-driven disk DMA controller.
// ----------------------------------------------------------------------------
module ddma_checker import ddma_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_stall,
    input logic [OP_W-1:0]    i_operation,
    input logic [VAL_W-1:0]   i_value,
    input logic [LOC_W-1:0]   i_location,
    input logic               o_valid,
    input logic               i_stall,
    input logic [VAL_W-1:0]   o_reply,
    input logic [PHASE_W-1:0] o_phase
);

    // The clearing pass keeps the input closed right after reset.
    a_clear_stall: assert property (@(posedge i_clk)
        !i_rst_n |=> o_stall)
        else $error("input open during store clearing");

    // Every accepted item other than a memory read has its result next cycle.
    a_quick_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_operation != OP_MEM_RD) |=> o_valid)
        else $error("result missing after a one-cycle item");

    // A memory read delivers its byte after the registered store lookup and the read step, with o_valid low in between.
    a_read_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_operation == OP_MEM_RD) |=> !o_valid ##1 o_valid)
        else $error("memory read result out of step");

    // In the hold phase only the phase-change echo or a byte can be replied.
    a_hold_reply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_phase == 2'd3) |-> (o_reply == CODE_NEXT || o_reply[31:8] == '0))
        else $error("unexpected reply in hold phase");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_reply) && $stable(o_phase)))
        else $error("stalled result changed");

endmodule

bind port_driven_disk_dma_controller ddma_checker u_checker (.*);
